// ----- rtl/ascii_setting_command_parser_unit_defines.svh -----
// Assertion helpers used by the assertion checker.
`ifndef ASCII_SETTING_COMMAND_PARSER_UNIT_DEFINES_SVH
`define ASCII_SETTING_COMMAND_PARSER_UNIT_DEFINES_SVH

// Same-cycle implication, masked while reset is asserted.
`define ASCP_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("ascp assertion failed");

// Next-cycle implication, masked while reset is asserted.
`define ASCP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("ascp assertion failed");

// Next-cycle implication that also holds across reset.
`define ASCP_ASSERT_ALWAYS(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("ascp assertion failed");

`endif

// ----- rtl/ascp_pkg.sv -----
package ascp_pkg;

    // Framing characters
    localparam logic [7:0] CH_START = 8'h3E;
    localparam logic [7:0] CH_END   = 8'h0A;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_MODE  = 8'h4D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_FOUR  = 8'h34;

    // Width of the value field on the result stream
    localparam int PARAM_VALUE_W = 31;
    localparam int M_TDATA_W     = 48;

    typedef enum logic [2:0] {
        EV_DONE    = 3'd0,
        EV_UNKNOWN = 3'd1,
        EV_NOSPACE = 3'd2,
        EV_BADMODE = 3'd3,
        EV_NODIGIT = 3'd4,
        EV_NOEND   = 3'd5,
        EV_RESTART = 3'd6
    } ascp_event_t;

    typedef enum logic [4:0] {
        PH_IDLE  = 5'b00001,
        PH_CODE  = 5'b00010,
        PH_SPACE = 5'b00100,
        PH_VALUE = 5'b01000,
        PH_END   = 5'b10000
    } ascp_phase_t;

    // One result item
    typedef struct packed {
        ascp_event_t              ev;
        logic [7:0]               code;
        logic [PARAM_VALUE_W-1:0] value;
        logic                     last;
    } ascp_result_t;

    // Command letters and digits that open a valid setting command
    function automatic logic code_accepted(input logic [7:0] c);
        logic ok;
        case (c)
            "s", "q", "M", "R", "I", "E", "P", "T", "t", "S", "V", "G", "H", "A",
            "d", "D", "c", "C", "b", "B",
            "1", "2", "3", "4", "5", "6", "7", "8", "9": ok = 1'b1;
            default: ok = 1'b0;
        endcase
        return ok;
    endfunction

endpackage

// ----- rtl/ascii_setting_command_parser_unit.sv -----
// ASCII setting command parser. Takes one received byte per request on the s_ stream and
// parses frames of the form '>' code ' ' value '\n', reporting errors and completed commands
// as result requests on the m_ stream; m_tlast marks the last result a byte causes. A byte is
// held in an input register, parsed combinationally and its zero, one or two results loaded
// into a two-entry result buffer. While m_tready is high, bytes with at most one result stream
// at one per cycle; a byte with two results (an outcome followed by a restart on '>') holds off
// the next byte until the result buffer has drained one entry. A byte's first result is offered
// from the result buffer, which is loaded from the input register. Values saturate at
// 2^VALUE_BITS - 1, and m_tdata carries the low 31 bits.
module ascii_setting_command_parser_unit #(
    parameter int VALUE_BITS = 31
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] rx_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // [2:0] event_res, [10:3] param_code, [41:11] param_value
    output logic        m_tlast
);
    import ascp_pkg::*;

    // Input register
    logic                  in_valid_reg, in_valid_next;
    logic [7:0]            in_byte_reg, in_byte_next;
    // Parser state
    ascp_phase_t           phase_reg, phase_next;
    logic [7:0]            code_reg, code_next;
    logic [VALUE_BITS-1:0] acc_reg, acc_next;
    // Result buffer
    logic [1:0]            cnt_reg, cnt_next;
    ascp_result_t          slot0_reg, slot0_next;
    ascp_result_t          slot1_reg, slot1_next;

    ascp_phase_t           core_phase;
    logic [7:0]            core_code;
    logic [VALUE_BITS-1:0] core_acc;
    logic [1:0]            core_cnt;
    ascp_result_t          core_res0;
    ascp_result_t          core_res1;
    logic                  in_fire;
    logic                  pop;
    logic                  load;

    ascp_core #(
        .VALUE_BITS(VALUE_BITS)
    ) u_core (
        .phase      (phase_reg),
        .code       (code_reg),
        .acc        (acc_reg),
        .rx         (in_byte_reg),
        .phase_next (core_phase),
        .code_next  (core_code),
        .acc_next   (core_acc),
        .res_cnt    (core_cnt),
        .res0       (core_res0),
        .res1       (core_res1)
    );

    // Handshake
    assign pop      = m_tvalid && m_tready;
    assign load     = in_valid_reg && ((cnt_reg == 2'd0) || ((cnt_reg == 2'd1) && pop));
    assign s_tready = !in_valid_reg || load;
    assign in_fire  = s_tvalid && s_tready;

    // Capture the next byte
    always_comb begin
        in_valid_next = in_valid_reg;
        in_byte_next  = in_byte_reg;
        if (in_fire) begin
            in_valid_next = 1'b1;
            in_byte_next  = s_tdata;
        end else if (load) begin
            in_valid_next = 1'b0;
        end
    end

    // Advance parser state when the byte's results fit in the buffer
    always_comb begin
        phase_next = phase_reg;
        code_next  = code_reg;
        acc_next   = acc_reg;
        if (load) begin
            phase_next = core_phase;
            code_next  = core_code;
            acc_next   = core_acc;
        end
    end

    // Load or drain the result buffer
    always_comb begin
        cnt_next   = cnt_reg;
        slot0_next = slot0_reg;
        slot1_next = slot1_reg;
        if (load) begin
            cnt_next   = core_cnt;
            slot0_next = core_res0;
            slot1_next = core_res1;
        end else if (pop) begin
            cnt_next   = cnt_reg - 2'd1;
            slot0_next = slot1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            phase_reg    <= PH_IDLE;
            code_reg     <= '0;
            acc_reg      <= '0;
            cnt_reg      <= '0;
        end else begin
            in_valid_reg <= in_valid_next;
            phase_reg    <= phase_next;
            code_reg     <= code_next;
            acc_reg      <= acc_next;
            cnt_reg      <= cnt_next;
        end
        in_byte_reg <= in_byte_next;
        slot0_reg   <= slot0_next;
        slot1_reg   <= slot1_next;
    end

    // Result stream
    assign m_tvalid = (cnt_reg != 2'd0);
    assign m_tdata  = {6'd0, slot0_reg.value, slot0_reg.code, slot0_reg.ev};
    assign m_tlast  = slot0_reg.last;

endmodule

// ----- rtl/ascp_core.sv -----
module ascp_core #(
    parameter int VALUE_BITS = 31
) (
    input  ascp_pkg::ascp_phase_t  phase,
    input  logic [7:0]             code,
    input  logic [VALUE_BITS-1:0]  acc,
    input  logic [7:0]             rx,
    output ascp_pkg::ascp_phase_t  phase_next,
    output logic [7:0]             code_next,
    output logic [VALUE_BITS-1:0]  acc_next,
    output logic [1:0]             res_cnt,
    output ascp_pkg::ascp_result_t res0,
    output ascp_pkg::ascp_result_t res1
);
    import ascp_pkg::*;

    localparam int WIDE_W = VALUE_BITS + 4;

    logic                     is_digit;
    logic                     is_mode_digit;
    logic [WIDE_W-1:0]        acc_ext;
    logic [WIDE_W-1:0]        acc_mac;
    logic [VALUE_BITS-1:0]    acc_sat;
    logic [31:0]              acc_32;
    logic                     has_prim;
    ascp_event_t              prim_ev;
    logic [PARAM_VALUE_W-1:0] prim_val;
    ascp_phase_t              phase_step;
    logic                     restart;

    assign is_digit      = (rx >= CH_ZERO) && (rx <= CH_NINE);
    assign is_mode_digit = (rx >= CH_ZERO) && (rx <= CH_FOUR);

    // Multiply by ten with shift-add, then saturate
    assign acc_ext = WIDE_W'(acc);
    assign acc_mac = (acc_ext << 3) + (acc_ext << 1) + WIDE_W'(rx[3:0]);
    assign acc_sat = (|acc_mac[WIDE_W-1:VALUE_BITS]) ? '1 : acc_mac[VALUE_BITS-1:0];
    assign acc_32  = 32'(acc);

    // Phase step and primary outcome
    always_comb begin
        phase_step = phase;
        code_next  = code;
        acc_next   = acc;
        has_prim   = 1'b0;
        prim_ev    = EV_DONE;
        prim_val   = '0;
        case (phase)
            PH_IDLE: begin
                if (rx == CH_START) phase_step = PH_CODE;
            end
            PH_CODE: begin
                acc_next = '0;
                if (code_accepted(rx)) begin
                    code_next  = rx;
                    phase_step = PH_SPACE;
                end else begin
                    code_next  = '0;
                    phase_step = PH_IDLE;
                    has_prim   = 1'b1;
                    prim_ev    = EV_UNKNOWN;
                end
            end
            PH_SPACE: begin
                if (rx == CH_SPACE) begin
                    phase_step = PH_VALUE;
                end else begin
                    phase_step = PH_IDLE;
                    has_prim   = 1'b1;
                    prim_ev    = EV_NOSPACE;
                end
            end
            PH_VALUE: begin
                if (code == CH_MODE) begin
                    if (is_mode_digit) begin
                        acc_next   = VALUE_BITS'(rx[2:0]);
                        phase_step = PH_END;
                    end else begin
                        phase_step = PH_IDLE;
                        has_prim   = 1'b1;
                        prim_ev    = EV_BADMODE;
                    end
                end else if (is_digit) begin
                    acc_next = acc_sat;
                end else if (rx == CH_END) begin
                    phase_step = PH_IDLE;
                    has_prim   = 1'b1;
                    prim_ev    = EV_DONE;
                    prim_val   = acc_32[PARAM_VALUE_W-1:0];
                end else begin
                    phase_step = PH_IDLE;
                    has_prim   = 1'b1;
                    prim_ev    = EV_NODIGIT;
                end
            end
            PH_END: begin
                phase_step = PH_IDLE;
                has_prim   = 1'b1;
                if (rx == CH_END) begin
                    prim_ev  = EV_DONE;
                    prim_val = acc_32[PARAM_VALUE_W-1:0];
                end else begin
                    prim_ev = EV_NOEND;
                end
            end
            default: begin
                phase_step = PH_IDLE;
            end
        endcase
    end

    // Start character in mid-frame restarts the frame
    assign restart    = (rx == CH_START) && (phase_step != PH_CODE);
    assign phase_next = restart ? PH_CODE : phase_step;
    assign res_cnt    = {1'b0, has_prim} + {1'b0, restart};

    // Order results: primary outcome first, restart after it
    always_comb begin
        res1.ev    = EV_RESTART;
        res1.code  = code_next;
        res1.value = '0;
        res1.last  = 1'b1;
        if (has_prim) begin
            res0.ev    = prim_ev;
            res0.code  = code_next;
            res0.value = prim_val;
            res0.last  = !restart;
        end else begin
            res0 = res1;
        end
    end

endmodule

// ----- rtl/ascp_checker.sv -----
`include "ascii_setting_command_parser_unit_defines.svh"

module ascp_assertions (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [47:0] m_tdata,
    input logic        m_tlast
);
    import ascp_pkg::*;

    logic       ev_done;
    logic       ev_restart;
    logic       ev_unknown;

    assign ev_done    = (m_tdata[2:0] == EV_DONE);
    assign ev_restart = (m_tdata[2:0] == EV_RESTART);
    assign ev_unknown = (m_tdata[2:0] == EV_UNKNOWN);

    // No result right after reset
    `ASCP_ASSERT_ALWAYS(a_reset_empty, aclk, !aresetn, !m_tvalid)
    // A stalled result stays offered
    `ASCP_ASSERT_NEXT(a_hold_valid, aclk, aresetn, m_tvalid && !m_tready, m_tvalid)
    // Only a completed command carries a value
    `ASCP_ASSERT_NOW(a_value_done, aclk, aresetn, m_tvalid && !ev_done, m_tdata[41:11] == 31'd0)
    // Restart is always the last result of its byte
    `ASCP_ASSERT_NOW(a_restart_last, aclk, aresetn, m_tvalid && ev_restart, m_tlast)
    // An unknown code clears the held code
    `ASCP_ASSERT_NOW(a_unknown_code, aclk, aresetn, m_tvalid && ev_unknown, m_tdata[10:3] == 8'd0)

endmodule

bind ascii_setting_command_parser_unit ascp_assertions u_ascp_assertions (.*);

// ----- tb/sv/ascp_checker.sv -----
`timescale 1ns / 1ps

module ascp_checker (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    input  logic                           s_tready,
    input  logic [7:0]                     s_tdata,   // [7:0] rx_byte
    input  logic                           m_tvalid,
    input  logic                           m_tready,
    input  logic [ascp_pkg::M_TDATA_W-1:0] m_tdata,   // [2:0] event_res, [10:3] param_code,
                                                      // [41:11] param_value
    input  logic                           m_tlast,
    output int                             mismatch_count,
    output int                             events_pending
);
    import ascp_pkg::*;

    localparam int          VB            = PARAM_VALUE_W;
    localparam logic [63:0] VALUE_MAX     = (64'd1 << VB) - 64'd1;
    localparam logic [63:0] RADIX         = 64'd10;
    localparam string       SETTING_CODES = "sqMRIEPTtSVGHAdDcCbB123456789";

    // Shadow parser state
    ascp_phase_t  phase_q;
    logic [7:0]   code_q;
    logic [63:0]  value_q;

    // Parse events predicted but not yet seen on the result stream
    ascp_result_t parse_events_q[$];

    function automatic logic is_setting_code(input logic [7:0] c);
        logic hit;
        hit = 1'b0;
        for (int i = 0; i < SETTING_CODES.len(); i++) begin
            if (SETTING_CODES[i] == c) begin
                hit = 1'b1;
            end
        end
        return hit;
    endfunction

    function automatic ascp_result_t make_event(input ascp_event_t ev, input logic [63:0] val);
        ascp_result_t r;
        r.ev    = ev;
        r.code  = code_q;
        r.value = val[VB-1:0];
        r.last  = 1'b0;
        return r;
    endfunction

    // Advance the shadow parser by one byte and queue the events it causes
    task automatic parse_rx_byte(input logic [7:0] b);
        ascp_result_t ev_buf[2];
        int           n;
        logic         is_digit;
        logic [63:0]  v;
        n        = 0;
        is_digit = (b >= CH_ZERO) && (b <= CH_NINE);
        case (phase_q)
            PH_IDLE: begin
                if (b == CH_START) begin
                    phase_q = PH_CODE;
                end
            end
            PH_CODE: begin
                value_q = '0;
                if (is_setting_code(b)) begin
                    code_q  = b;
                    phase_q = PH_SPACE;
                end else begin
                    code_q    = '0;
                    phase_q   = PH_IDLE;
                    ev_buf[n] = make_event(EV_UNKNOWN, '0);
                    n         = n + 1;
                end
            end
            PH_SPACE: begin
                if (b == CH_SPACE) begin
                    phase_q = PH_VALUE;
                end else begin
                    phase_q   = PH_IDLE;
                    ev_buf[n] = make_event(EV_NOSPACE, '0);
                    n         = n + 1;
                end
            end
            PH_VALUE: begin
                if (code_q == CH_MODE) begin
                    // mode takes exactly one digit 0..4
                    if (b >= CH_ZERO && b <= CH_FOUR) begin
                        value_q = 64'(b - CH_ZERO);
                        phase_q = PH_END;
                    end else begin
                        phase_q   = PH_IDLE;
                        ev_buf[n] = make_event(EV_BADMODE, '0);
                        n         = n + 1;
                    end
                end else if (is_digit) begin
                    // accumulate, saturating at the top of the value range
                    v       = value_q * RADIX + 64'(b - CH_ZERO);
                    value_q = (v > VALUE_MAX) ? VALUE_MAX : v;
                end else if (b == CH_END) begin
                    phase_q   = PH_IDLE;
                    ev_buf[n] = make_event(EV_DONE, value_q);
                    n         = n + 1;
                end else begin
                    phase_q   = PH_IDLE;
                    ev_buf[n] = make_event(EV_NODIGIT, '0);
                    n         = n + 1;
                end
            end
            PH_END: begin
                phase_q = PH_IDLE;
                if (b == CH_END) begin
                    ev_buf[n] = make_event(EV_DONE, value_q);
                end else begin
                    ev_buf[n] = make_event(EV_NOEND, '0);
                end
                n = n + 1;
            end
            default: begin
                phase_q = PH_IDLE;
            end
        endcase

        // a start character in mid-frame restarts the frame after its own outcome
        if (b == CH_START && phase_q != PH_CODE) begin
            phase_q   = PH_CODE;
            ev_buf[n] = make_event(EV_RESTART, '0);
            n         = n + 1;
        end

        if (n > 0) begin
            ev_buf[n-1].last = 1'b1;
        end
        for (int i = 0; i < n; i++) begin
            parse_events_q.push_back(ev_buf[i]);
        end
    endtask

    // Compare each result request with the oldest prediction, then predict new ones
    always @(posedge aclk) begin
        ascp_result_t         exp_ev;
        logic [M_TDATA_W-1:0] exp_tdata;
        if (!aresetn) begin
            phase_q        = PH_IDLE;
            code_q         = '0;
            value_q        = '0;
            mismatch_count = 0;
            parse_events_q.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                if (parse_events_q.size() == 0) begin
                    mismatch_count = mismatch_count + 1;
                    // tdata/last
                    $display("%0t: unexpected result: expected none, got %012h/%0b",
                             $time, m_tdata, m_tlast);
                end else begin
                    exp_ev    = parse_events_q.pop_front();
                    exp_tdata = M_TDATA_W'({exp_ev.value, exp_ev.code, exp_ev.ev});
                    if (m_tdata !== exp_tdata || m_tlast !== exp_ev.last) begin
                        mismatch_count = mismatch_count + 1;
                        // tdata/last
                        $display("%0t: result mismatch: expected %012h/%0b, got %012h/%0b",
                                 $time, exp_tdata, exp_ev.last, m_tdata, m_tlast);
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                parse_rx_byte(s_tdata);
            end
        end
        events_pending = parse_events_q.size();
    end

endmodule

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
    import ascp_pkg::*;

    localparam int    CLK_PERIOD    = 20;
    localparam int    RESET_CYCLES  = 4;
    localparam int    STREAM_ITEMS  = 650;
    localparam int    CALM_TAIL     = 100;
    localparam int    HOLD_AT       = 250;
    localparam int    HOLD_CYCLES   = 300;
    localparam int    STALL_LIMIT   = 2000;
    localparam int    DRAIN_CYCLES  = 20;
    localparam string SETTING_CODES = "sqMRIEPTtSVGHAdDcCbB123456789";

    logic                 aclk;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic [7:0]           s_tdata  = '0;   // [7:0] rx_byte
    logic                 m_tready = 1'b0;
    logic                 s_tready;
    logic                 m_tvalid;
    logic [M_TDATA_W-1:0] m_tdata;         // [2:0] event_res, [10:3] param_code,
                                           // [41:11] param_value
    logic                 m_tlast;

    int         mismatch_count;
    int         events_pending;
    int         bytes_sent  = 0;
    int         stall_cycles = 0;
    logic       calm        = 1'b0;
    logic       hold_done   = 1'b0;
    logic [7:0] rx_stream[$];

    ascii_setting_command_parser_unit u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    ascp_checker u_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tlast        (m_tlast),
        .mismatch_count (mismatch_count),
        .events_pending (events_pending)
    );

    initial begin
        aclk = 1'b0;
        forever #(CLK_PERIOD / 2) aclk = ~aclk;
    end

    task automatic add_text(input string t);
        for (int i = 0; i < t.len(); i++) begin
            rx_stream.push_back(t[i]);
        end
    endtask

    // Receiver: random ready bursts, one long hold-off mid-run, none in the tail
    initial begin
        int burst;
        forever begin
            if (!calm && !hold_done && bytes_sent >= HOLD_AT) begin
                @(negedge aclk) m_tready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge aclk);
                hold_done = 1'b1;
            end else if (!calm && $urandom_range(0, 3) == 0) begin
                burst = $urandom_range(1, 18);
                @(negedge aclk) m_tready <= 1'b0;
                repeat (burst - 1) @(negedge aclk);
            end else begin
                burst = $urandom_range(1, 12);
                @(negedge aclk) m_tready <= 1'b1;
                repeat (burst - 1) @(negedge aclk);
            end
        end
    end

    // Abort when no request moves on either side for too long
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                stall_cycles = 0;
            end else begin
                stall_cycles = stall_cycles + 1;
            end
            if (stall_cycles >= STALL_LIMIT) begin
                $display("[ascii_setting_command_parser_unit] ERROR");
                $finish;
            end
        end
    end

    // Stimulus and verdict
    initial begin
        int          counted;
        int          kind;
        int          ndig;
        int          cut;
        int          gap;
        logic [7:0]  code;
        logic [7:0]  frame[$];

        // directed: complete mode, unknown code, missing space with restart,
        // bad mode digit, missing end with restart, non-digit with restart,
        // empty value, and byte extremes while waiting for a start
        add_text(">M 4\n>x>q>M 5");
        rx_stream.push_back(8'h00);
        rx_stream.push_back(8'hFF);
        add_text(">M 0>t 12>9 \n");

        // random: mostly well-formed frames, some corrupted, some line noise
        counted = rx_stream.size();
        while (counted < STREAM_ITEMS) begin
            kind = $urandom_range(0, 99);
            frame.delete();
            if (kind < 85) begin
                code = SETTING_CODES[$urandom_range(0, SETTING_CODES.len() - 1)];
                frame.push_back(CH_START);
                frame.push_back(code);
                frame.push_back(CH_SPACE);
                if (code == CH_MODE) begin
                    frame.push_back(CH_ZERO + 8'($urandom_range(0, 4)));
                end else begin
                    // occasional long values drive saturation
                    ndig = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 12)
                                                       : $urandom_range(0, 5);
                    repeat (ndig) frame.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
                end
                frame.push_back(CH_END);
                if (kind >= 65) begin
                    // break the frame at a random point and drop the rest
                    cut = $urandom_range(1, frame.size() - 1);
                    frame[cut] = ($urandom_range(0, 3) == 0) ? CH_START
                                                             : 8'($urandom_range(0, 255));
                    while (frame.size() > cut + 1) void'(frame.pop_back());
                end
                counted = counted + frame.size();
                foreach (frame[i]) rx_stream.push_back(frame[i]);
            end else begin
                repeat ($urandom_range(1, 4)) begin
                    rx_stream.push_back(8'($urandom_range(0, 255)));
                    counted = counted + 1;
                end
            end
        end

        // hold reset, then release
        repeat (RESET_CYCLES) @(posedge aclk);
        @(negedge aclk) aresetn <= 1'b1;

        // send every byte, with random gaps outside the tail
        for (int idx = 0; idx < rx_stream.size(); idx++) begin
            calm = (idx >= rx_stream.size() - CALM_TAIL);
            @(negedge aclk);
            s_tvalid <= 1'b1;
            s_tdata  <= rx_stream[idx];
            @(posedge aclk);
            while (!s_tready) @(posedge aclk);
            bytes_sent = bytes_sent + 1;
            if (!calm && $urandom_range(0, 3) == 0) begin
                gap = $urandom_range(1, 18);
                @(negedge aclk) s_tvalid <= 1'b0;
                repeat (gap - 1) @(negedge aclk);
            end
        end
        @(negedge aclk) s_tvalid <= 1'b0;

        // drain outstanding results, then allow for any stray late ones
        while (events_pending != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);

        if (mismatch_count == 0) begin
            $display("[ascii_setting_command_parser_unit] OK");
        end else begin
            $display("[ascii_setting_command_parser_unit] ERROR");
        end
        $finish;
    end

endmodule
